// File: rtl/core/mft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mft_pkg: shared types and constants for the message flag table
// Flag encodings, action codes, register indexes and the command and result
// records that pass between the sequencer and the flag update unit.
// ----------------------------------------------------------------------------
package mft_pkg;

	// Table geometry
	localparam int MSG_COUNT = 32;
	localparam int IDX_W     = (MSG_COUNT > 1) ? $clog2(MSG_COUNT) : 1;
	localparam int MSG_W     = 5;
	localparam int RANGE_W   = 9;
	localparam int FLAG_W    = 2;

	// Field widths
	localparam int ACT_W       = 3;
	localparam int LIMIT_W     = 8;
	localparam int TICK_W      = 8;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 8;

	// Register reset values
	localparam logic [LIMIT_W-1:0] WD_LIMIT_RST = LIMIT_W'(10);
	localparam logic [MSG_W-1:0]   WD_MSG_RST   = '0;

	// Flag states
	localparam logic [FLAG_W-1:0] FLAG_OFF    = 2'd0;
	localparam logic [FLAG_W-1:0] FLAG_POSTED = 2'd1;
	localparam logic [FLAG_W-1:0] FLAG_ACTIVE = 2'd2;

	typedef enum logic [ACT_W-1:0] {
		ACT_SEND    = 3'd0,
		ACT_SEND_BC = 3'd1,
		ACT_GET     = 3'd2,
		ACT_GET_BC  = 3'd3,
		ACT_TICK    = 3'd4,
		ACT_WDOG    = 3'd5
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WD_LIMIT = 1'b0,
		REG_WD_MSG   = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		OP_NONE      = 3'd0,
		OP_POST      = 3'd1,
		OP_GET_CLEAR = 3'd2,
		OP_GET_KEEP  = 3'd3,
		OP_ADVANCE   = 3'd4
	} flag_op_t;

	typedef struct packed {
		flag_op_t          op;
		logic [FLAG_W-1:0] flag;
	} flag_cmd_t;

	typedef struct packed {
		logic [FLAG_W-1:0] flag;
		logic              active;
		logic              moved;
	} flag_res_t;

endpackage
`default_nettype wire

// File: rtl/core/mft_flag_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mft_flag_unit: update unit for one three-state message flag
// Applies post, get, get-and-clear or advance to the current flag value and
// reports the next value, whether the flag was active and, for advance, whether it moved.
// ----------------------------------------------------------------------------
module mft_flag_unit (
	input  mft_pkg::flag_cmd_t cmd,
	output mft_pkg::flag_res_t res
);
	import mft_pkg::*;

	// Compute next flag value
	always_comb begin
		res.flag   = cmd.flag;
		res.active = (cmd.flag == FLAG_ACTIVE);
		res.moved  = 1'b0;
		case (cmd.op)
			OP_POST: begin
				if (cmd.flag == FLAG_OFF) begin
					res.flag = FLAG_POSTED;
				end
			end
			OP_GET_CLEAR: begin
				if (cmd.flag == FLAG_ACTIVE) begin
					res.flag = FLAG_OFF;
				end
			end
			OP_ADVANCE: begin
				if (cmd.flag == FLAG_ACTIVE) begin
					res.flag  = FLAG_OFF;
					res.moved = 1'b1;
				end else if (cmd.flag == FLAG_POSTED) begin
					res.flag  = FLAG_ACTIVE;
					res.moved = 1'b1;
				end
			end
			default: begin
				res.flag = cmd.flag;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/core/message_flag_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// message_flag_table: direct and broadcast message flag tables
// Sequencer around a shared flag update unit (one per table) that posts,
// reads, clears and advances three-state message flags, plus an idle
// watchdog that posts a configured direct message.
// ----------------------------------------------------------------------------
//
//  channel  handshake             payload
//  -------  --------------------  -----------------------------------------
//  in       in_valid / in_stall   action, msg_index
//  out      out_valid / out_stall reply, any_active, watchdog_fired
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
//  Send, get, watchdog and unused actions go from accept through one update
//  of the addressed entry (S_EXEC) and the reply before the next accept.
//  A process tick sweeps the MSG_COUNT entries one per cycle through the
//  update units, then replies.
//  Reset clears both tables, the idle counter and the activity bit at once;
//  no clearing pass follows. Configuration writes are always ready.
//  A stalled output holds the sequencer in its reply state until taken.
//
module message_flag_table (
	input  wire                             clk,
	input  wire                             arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [mft_pkg::ACT_W-1:0]       action,
	input  logic [mft_pkg::MSG_W-1:0]       msg_index,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            reply,
	output logic                            any_active,
	output logic                            watchdog_fired,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mft_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mft_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import mft_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_EXEC  = 4'b0010,
		S_SWEEP = 4'b0100,
		S_REPLY = 4'b1000
	} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MSG_COUNT - 1);

	state_t                state_q;
	logic [ACT_W-1:0]      act_q;
	logic [MSG_W-1:0]      idx_q;
	logic [IDX_W-1:0]      cnt_q;
	logic                  moved_q;
	logic [FLAG_W-1:0]     dir_q [MSG_COUNT];
	logic [FLAG_W-1:0]     bc_q  [MSG_COUNT];
	logic [TICK_W-1:0]     idle_q;
	logic                  activity_q;
	logic [LIMIT_W-1:0]    wd_limit_q;
	logic [MSG_W-1:0]      wd_msg_q;
	logic                  res_reply_q;
	logic                  res_fired_q;
	logic                  out_valid_q;
	logic                  reply_q;
	logic                  any_active_q;
	logic                  fired_q;

	logic                  in_accept;
	logic                  out_load;
	logic [TICK_W-1:0]     idle_inc;
	logic                  wd_fire;
	logic [MSG_W-1:0]      sel_msg;
	logic                  sel_ok;
	logic [IDX_W-1:0]      addr;
	flag_cmd_t             dir_cmd;
	flag_cmd_t             bc_cmd;
	flag_res_t             dir_res;
	flag_res_t             bc_res;
	logic                  exec_reply;

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_load  = (state_q == S_REPLY) && (!out_valid_q || !out_stall);

	// Watchdog count and fire decision
	assign idle_inc = idle_q + TICK_W'(1);
	assign wd_fire  = (action_t'(act_q) == ACT_WDOG) && !activity_q
		&& (idle_inc >= wd_limit_q);

	// Select the entry to work on
	assign sel_msg = (action_t'(act_q) == ACT_WDOG) ? wd_msg_q : idx_q;
	assign sel_ok  = (RANGE_W'(sel_msg) < RANGE_W'(MSG_COUNT));
	assign addr    = (state_q == S_SWEEP) ? cnt_q : IDX_W'(sel_msg);

	// Drive the update units
	always_comb begin
		dir_cmd.flag = dir_q[addr];
		bc_cmd.flag  = bc_q[addr];
		dir_cmd.op   = OP_NONE;
		bc_cmd.op    = OP_NONE;
		exec_reply   = 1'b0;
		if (state_q == S_SWEEP) begin
			dir_cmd.op = OP_ADVANCE;
			bc_cmd.op  = OP_ADVANCE;
		end else if (state_q == S_EXEC && sel_ok) begin
			case (action_t'(act_q))
				ACT_SEND: begin
					dir_cmd.op = OP_POST;
				end
				ACT_SEND_BC: begin
					bc_cmd.op = OP_POST;
				end
				ACT_GET: begin
					dir_cmd.op = OP_GET_CLEAR;
					exec_reply = dir_res.active;
				end
				ACT_GET_BC: begin
					bc_cmd.op  = OP_GET_KEEP;
					exec_reply = bc_res.active;
				end
				ACT_WDOG: begin
					dir_cmd.op = wd_fire ? OP_POST : OP_NONE;
				end
				default: begin
					dir_cmd.op = OP_NONE;
				end
			endcase
		end
	end

	mft_flag_unit u_dir_unit (
		.cmd (dir_cmd),
		.res (dir_res)
	);

	mft_flag_unit u_bc_unit (
		.cmd (bc_cmd),
		.res (bc_res)
	);

	// Write back the updated entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MSG_COUNT; i++) begin
				dir_q[i] <= FLAG_OFF;
				bc_q[i]  <= FLAG_OFF;
			end
		end else if (state_q == S_EXEC || state_q == S_SWEEP) begin
			dir_q[addr] <= dir_res.flag;
			bc_q[addr]  <= bc_res.flag;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wd_limit_q <= WD_LIMIT_RST;
			wd_msg_q   <= WD_MSG_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_WD_LIMIT: begin
					wd_limit_q <= cfg_data[LIMIT_W-1:0];
				end
				REG_WD_MSG: begin
					wd_msg_q <= cfg_data[MSG_W-1:0];
				end
				default: begin
					wd_limit_q <= wd_limit_q;
				end
			endcase
		end
	end

	// Capture the accepted transaction
	always_ff @(posedge clk) begin
		if (in_accept) begin
			act_q <= action;
			idx_q <= msg_index;
		end
	end

	// Sequencer, sweep counter, watchdog and activity state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			moved_q     <= 1'b0;
			idle_q      <= '0;
			activity_q  <= 1'b0;
			res_reply_q <= 1'b0;
			res_fired_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						cnt_q   <= '0;
						moved_q <= 1'b0;
						state_q <= (action_t'(action) == ACT_TICK) ? S_SWEEP : S_EXEC;
					end
				end
				S_EXEC: begin
					res_reply_q <= exec_reply;
					res_fired_q <= wd_fire;
					if (action_t'(act_q) == ACT_WDOG) begin
						idle_q <= activity_q ? '0 : idle_inc;
					end
					state_q <= S_REPLY;
				end
				S_SWEEP: begin
					moved_q <= moved_q | dir_res.moved | bc_res.moved;
					if (cnt_q == LAST_IDX) begin
						activity_q  <= moved_q | dir_res.moved | bc_res.moved;
						res_reply_q <= 1'b0;
						res_fired_q <= 1'b0;
						state_q     <= S_REPLY;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				S_REPLY: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			reply_q      <= res_reply_q;
			any_active_q <= activity_q;
			fired_q      <= res_fired_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign reply          = reply_q;
	assign any_active     = any_active_q;
	assign watchdog_fired = fired_q;

	// A new result appears only out of the reply state
	a_out_from_reply: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_REPLY))
		else $error("result presented outside reply state");

	// A sweep always starts at the first entry
	a_sweep_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP && $past(state_q == S_IDLE)) |-> (cnt_q == '0))
		else $error("sweep did not start at entry zero");

	// The last sweep entry hands over to the reply
	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP && cnt_q == LAST_IDX) |=> (state_q == S_REPLY))
		else $error("sweep did not finish after last entry");

	// A get and a watchdog fire never share a result
	a_reply_fire: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REPLY) |-> !(res_reply_q && res_fired_q))
		else $error("reply and watchdog fire both set");

endmodule
`default_nettype wire
